// ===== rtl/ascii_length_prefix_deframer_assert.svh =====
// Assertion macros for the ASCII length-prefix deframer.
// Used by the top level only; needs nothing else.
`ifndef ASCII_LENGTH_PREFIX_DEFRAMER_ASSERT_SVH
`define ASCII_LENGTH_PREFIX_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ALPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("deframer check failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ALPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("deframer check failed: next-cycle implication");

`endif

// ===== rtl/alpd_pkg.sv =====
// Shared types, constants and width helpers for the ASCII length-prefix deframer.
// No dependencies.
package alpd_pkg;

	// Default number of decimal digits in a header
	localparam int HEADER_DIGITS_DEF = 4;

	// ASCII digit bounds
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// Bits needed to hold 10^hd - 1
	function automatic int len_width(input int hd);
		int p;
		p = 1;
		for (int i = 0; i < hd; i++) begin
			p = p * 10;
		end
		return $clog2(p);
	endfunction

	// Bits needed for a digit counter of 0 .. hd-1
	function automatic int run_width(input int hd);
		return (hd > 1) ? $clog2(hd) : 1;
	endfunction

	// One result word between core and output register
	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic       last_of_message;
		logic       empty_message;
	} alpd_result_t;

endpackage

// ===== rtl/alpd_core.sv =====
// Deframer state and per-byte step logic: header hunt, length accumulate,
// payload countdown. Depends on alpd_pkg.
module alpd_core #(
	parameter int HEADER_DIGITS = alpd_pkg::HEADER_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          in_byte,
	output alpd_pkg::alpd_result_t res
);

	localparam int LEN_W = alpd_pkg::len_width(HEADER_DIGITS);
	localparam int RUN_W = alpd_pkg::run_width(HEADER_DIGITS);
	localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(HEADER_DIGITS - 1);

	logic             in_payload_q, in_payload_d;
	logic [RUN_W-1:0] digit_run_q, digit_run_d;
	logic [LEN_W-1:0] length_accum_q, length_accum_d;
	logic [LEN_W-1:0] bytes_left_q, bytes_left_d;

	logic             is_digit;
	logic [3:0]       digit;
	logic [LEN_W-1:0] acc_new;

	// Digit decode and multiply-by-ten accumulate
	assign is_digit = (in_byte >= alpd_pkg::CHAR_ZERO) && (in_byte <= alpd_pkg::CHAR_NINE);
	assign digit    = 4'(in_byte - alpd_pkg::CHAR_ZERO);
	assign acc_new  = (length_accum_q << 3) + (length_accum_q << 1) + LEN_W'(digit);

	// Next state and result
	always_comb begin
		in_payload_d   = in_payload_q;
		digit_run_d    = digit_run_q;
		length_accum_d = length_accum_q;
		bytes_left_d   = bytes_left_q;
		res            = '0;
		if (in_payload_q) begin
			res.valid        = 1'b1;
			res.payload_byte = in_byte;
			if (bytes_left_q <= LEN_W'(1)) begin
				res.last_of_message = 1'b1;
				in_payload_d        = 1'b0;
				bytes_left_d        = '0;
			end else begin
				bytes_left_d = bytes_left_q - LEN_W'(1);
			end
		end else if (!is_digit) begin
			// non-digit while hunting: drop and restart the run
			digit_run_d    = '0;
			length_accum_d = '0;
		end else begin
			length_accum_d = acc_new;
			if (digit_run_q != RUN_LAST) begin
				digit_run_d = digit_run_q + RUN_W'(1);
			end else begin
				digit_run_d = '0;
				if (acc_new == '0) begin
					// zero-length message
					res.valid           = 1'b1;
					res.last_of_message = 1'b1;
					res.empty_message   = 1'b1;
				end else begin
					bytes_left_d   = acc_new;
					length_accum_d = '0;
					in_payload_d   = 1'b1;
				end
			end
		end
	end

	// State registers, updated only when a word is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q   <= 1'b0;
			digit_run_q    <= '0;
			length_accum_q <= '0;
			bytes_left_q   <= '0;
		end else if (step) begin
			in_payload_q   <= in_payload_d;
			digit_run_q    <= digit_run_d;
			length_accum_q <= length_accum_d;
			bytes_left_q   <= bytes_left_d;
		end
	end

endmodule

// ===== rtl/alpd_out_reg.sv =====
// Output register of the deframer: holds one result word until taken.
// Depends on alpd_pkg.
module alpd_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  alpd_pkg::alpd_result_t res_in,
	output logic                   msg_valid,
	output logic [7:0]             payload_byte,
	output logic                   last_of_message,
	output logic                   empty_message
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       empty_q;

	// Valid flag: refilled whenever the register is free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_in.valid;
		end
	end

	// Payload: captured only with a real result
	always_ff @(posedge clk) begin
		if (load && res_in.valid) begin
			byte_q  <= res_in.payload_byte;
			last_q  <= res_in.last_of_message;
			empty_q <= res_in.empty_message;
		end
	end

	assign msg_valid       = valid_q;
	assign payload_byte    = byte_q;
	assign last_of_message = last_q;
	assign empty_message   = empty_q;

endmodule

// ===== rtl/ascii_length_prefix_deframer.sv =====
// A byte in the input register steps alpd_core; any result is held in alpd_out_reg.
// Throughput: one byte per cycle while a full output register is not held by msg_stall;
// the alpd_core state update (multiply-by-ten accumulate, payload countdown) is combinational.
// Reset (arst_n low, asynchronous) empties both registers and returns to header hunting.
// Top level: input register, alpd_core, alpd_out_reg; uses alpd_pkg and the assert header.
`include "ascii_length_prefix_deframer_assert.svh"

module ascii_length_prefix_deframer #(
	parameter int HEADER_DIGITS = alpd_pkg::HEADER_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] in_byte,
	output logic       msg_valid,
	input  logic       msg_stall,
	output logic [7:0] payload_byte,
	output logic       last_of_message,
	output logic       empty_message
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance;
	alpd_pkg::alpd_result_t core_res;
	alpd_pkg::alpd_result_t out_res;

	// Pipeline moves when the output register is free or being taken
	assign advance    = !msg_valid || !msg_stall;
	assign byte_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= in_byte;
		end
	end

	alpd_core #(
		.HEADER_DIGITS(HEADER_DIGITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.in_byte (byte_s1),
		.res     (core_res)
	);

	// Gate the result with the stage valid
	always_comb begin
		out_res       = core_res;
		out_res.valid = core_res.valid && valid_s1;
	end

	alpd_out_reg u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (advance),
		.res_in          (out_res),
		.msg_valid       (msg_valid),
		.payload_byte    (payload_byte),
		.last_of_message (last_of_message),
		.empty_message   (empty_message)
	);

	// Checks
	`ALPD_ASSERT_IMP(a_empty_is_last, clk, arst_n, msg_valid && empty_message, last_of_message && (payload_byte == 8'h00))
	`ALPD_ASSERT_IMP(a_stall_needs_s1, clk, arst_n, byte_stall, valid_s1)
	`ALPD_ASSERT_NXT(a_s1_holds, clk, arst_n, valid_s1 && msg_valid && msg_stall, valid_s1 && $stable(byte_s1))

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for ascii_length_prefix_deframer: directed rows, then random framed traffic.
// Holds its own deframing predictor and checks every msg word in order against it.
// Needs alpd_pkg and the RTL of the block; reads no files.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HDR_DIGITS = alpd_pkg::HEADER_DIGITS_DEF;
	localparam int LEN_W = alpd_pkg::len_width(HDR_DIGITS);
	localparam int RUN_W = alpd_pkg::run_width(HDR_DIGITS);
	localparam int MAX_LEN = 10 ** HDR_DIGITS - 1;
	localparam int RANDOM_WORDS = 1550;
	localparam int LAT_SLACK = 6;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PRINT_CAP = 40;
	localparam int OPEN_TAIL = 16;

	// One word on the msg side
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
	} msg_word_t;

	// One directed row: the byte sent and, where typed in, the word it must give
	typedef struct packed {
		logic [7:0] data;
		bit         typed;
		bit         gives;
		msg_word_t  word;
	} stim_row_t;

	typedef enum int {
		STALL_NONE,
		STALL_SPARSE,
		STALL_HEAVY,
		STALL_ALTERNATE
	} stall_mode_t;

	localparam msg_word_t NO_WORD = '{8'h00, 1'b0, 1'b0};

	// Directed rows: drops, empty message, broken headers, one- and two-byte messages
	localparam int N_ROWS = 23;
	localparam stim_row_t ROWS [N_ROWS] = '{
		'{8'h41, 1'b1, 1'b0, NO_WORD},              // non-digit while hunting
		'{8'h30, 1'b1, 1'b0, NO_WORD},
		'{8'h30, 1'b1, 1'b0, NO_WORD},
		'{8'h30, 1'b1, 1'b0, NO_WORD},
		'{8'h30, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}, // zero length: empty message
		'{8'h31, 1'b1, 1'b0, NO_WORD},
		'{8'h2f, 1'b1, 1'b0, NO_WORD},              // just below '0' breaks the run
		'{8'h3a, 1'b1, 1'b0, NO_WORD},              // just above '9'
		'{8'h30, 1'b1, 1'b0, NO_WORD},
		'{8'h30, 1'b1, 1'b0, NO_WORD},
		'{8'h30, 1'b1, 1'b0, NO_WORD},
		'{8'h31, 1'b1, 1'b0, NO_WORD},              // header complete, no word
		'{8'hff, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b0}}, // single-byte message
		'{8'h30, 1'b1, 1'b0, NO_WORD},
		'{8'h30, 1'b1, 1'b0, NO_WORD},
		'{8'h30, 1'b1, 1'b0, NO_WORD},
		'{8'h32, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{8'h35, 1'b1, 1'b1, '{8'h35, 1'b1, 1'b0}}, // digit inside payload is data
		'{8'h39, 1'b1, 1'b0, NO_WORD},
		'{8'h38, 1'b1, 1'b0, NO_WORD},
		'{8'h37, 1'b1, 1'b0, NO_WORD},
		'{8'h2f, 1'b1, 1'b0, NO_WORD}               // broken after three digits
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic [7:0] in_byte = 8'h00;
	logic       msg_valid;
	logic       msg_stall = 1'b0;
	logic [7:0] payload_byte;
	logic       last_of_message;
	logic       empty_message;

	ascii_length_prefix_deframer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.in_byte         (in_byte),
		.msg_valid       (msg_valid),
		.msg_stall       (msg_stall),
		.payload_byte    (payload_byte),
		.last_of_message (last_of_message),
		.empty_message   (empty_message)
	);

	// Predictor state
	bit               pr_in_payload;
	logic [RUN_W-1:0] pr_digit_run;
	logic [LEN_W-1:0] pr_length;
	logic [LEN_W-1:0] pr_bytes_left;

	msg_word_t   due_words [$];
	int          errors;
	int          cycles;
	int          burst_left;
	int          counted_words;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_phase;
	logic        mon_seen;
	msg_word_t   mon_got;
	msg_word_t   mon_want;

	always #6 clk = ~clk;

	// Advance the deframer state by one byte; returns 1 when a msg word is due
	function automatic bit deframe_byte(input logic [7:0] b, output msg_word_t w);
		w = NO_WORD;
		if (pr_in_payload) begin
			w.data = b;
			if (pr_bytes_left <= 1) begin
				w.last = 1'b1;
				pr_in_payload = 1'b0;
				pr_bytes_left = '0;
			end else begin
				pr_bytes_left = pr_bytes_left - 1'b1;
			end
			return 1'b1;
		end
		if (b < alpd_pkg::CHAR_ZERO || b > alpd_pkg::CHAR_NINE) begin
			pr_digit_run = '0;
			pr_length = '0;
			return 1'b0;
		end
		pr_length = LEN_W'(pr_length * 10 + (b - alpd_pkg::CHAR_ZERO));
		if (int'(pr_digit_run) + 1 < HDR_DIGITS) begin
			pr_digit_run = pr_digit_run + 1'b1;
			return 1'b0;
		end
		pr_digit_run = '0;
		if (pr_length == 0) begin
			w.last = 1'b1;
			w.empty = 1'b1;
			return 1'b1;
		end
		pr_bytes_left = pr_length;
		pr_length = '0;
		pr_in_payload = 1'b1;
		return 1'b0;
	endfunction

	task automatic flag_mismatch(input string what, input int got_v, input int want_v);
		errors++;
		if (errors <= PRINT_CAP)
			$display("mismatch: %s: got %0d, wanted %0d", what, got_v, want_v);
	endtask

	// Send one byte in bursts; a typed row overrides the predicted word
	task automatic send_word(input logic [7:0] b, input bit typed, input bit gives,
			input msg_word_t typed_word);
		int        gap;
		bit        took;
		bit        has_word;
		msg_word_t w;
		if (burst_left == 0) begin
			byte_valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		byte_valid <= 1'b1;
		in_byte <= b;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = !byte_stall;
			@(posedge clk);
		end
		burst_left--;
		has_word = deframe_byte(b, w);
		if (typed) begin
			has_word = gives;
			w = typed_word;
		end
		if (has_word)
			due_words.insert(due_words.size(), w);
	endtask

	// Sender holds off until every due word has come out
	task automatic wait_for_drain();
		byte_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (LAT_SLACK) @(posedge clk);
	endtask

	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b >= alpd_pkg::CHAR_ZERO && b <= alpd_pkg::CHAR_NINE)
			b = b ^ 8'h40;
		return b;
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return 0;
		if (r < 80)
			return $urandom_range(1, 12);
		if (r < 97)
			return $urandom_range(13, 100);
		return $urandom_range(101, 999);
	endfunction

	// Header digits, most significant first
	task automatic send_head(input int len);
		int div;
		div = 10 ** (HDR_DIGITS - 1);
		for (int i = 0; i < HDR_DIGITS; i++) begin
			send_word(alpd_pkg::CHAR_ZERO + 8'((len / div) % 10), 1'b0, 1'b0, NO_WORD);
			div = div / 10;
		end
	endtask

	// Header, then random payload bytes
	task automatic send_frame(input int len, input bit counts);
		send_head(len);
		for (int i = 0; i < len; i++)
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_WORD);
		if (counts)
			counted_words += HDR_DIGITS + len;
	endtask

	// A header cut short by a non-digit
	task automatic send_broken();
		int n;
		n = $urandom_range(1, HDR_DIGITS - 1);
		for (int i = 0; i < n; i++)
			send_word(alpd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b0, NO_WORD);
		send_word(noise_byte(), 1'b0, 1'b0, NO_WORD);
	endtask

	// Receiver stall pattern: a mode held for a random stretch
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_phase <= $urandom_range(16, 80);
		end else begin
			stall_phase <= stall_phase - 1;
		end
		case (stall_mode)
			STALL_NONE: msg_stall <= 1'b0;
			STALL_SPARSE: msg_stall <= ($urandom_range(0, 2) == 0);
			STALL_HEAVY: msg_stall <= ($urandom_range(0, 9) < 8);
			default: msg_stall <= !msg_stall;
		endcase
	end

	// Sample before the edge, check the word taken at the edge
	always begin
		@(negedge clk);
		mon_seen = arst_n && msg_valid && !msg_stall;
		mon_got = '{payload_byte, last_of_message, empty_message};
		@(posedge clk);
		if (mon_seen) begin
			if (due_words.size() == 0) begin
				flag_mismatch("msg word with none due", mon_got.data, -1);
			end else begin
				mon_want = due_words.pop_front();
				if (mon_got.data !== mon_want.data)
					flag_mismatch("payload_byte", mon_got.data, mon_want.data);
				if (mon_got.last !== mon_want.last)
					flag_mismatch("last_of_message", mon_got.last, mon_want.last);
				if (mon_got.empty !== mon_want.empty)
					flag_mismatch("empty_message", mon_got.empty, mon_want.empty);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int pick;
		pr_in_payload = 1'b0;
		pr_digit_run = '0;
		pr_length = '0;
		pr_bytes_left = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_word(ROWS[i].data, ROWS[i].typed, ROWS[i].gives, ROWS[i].word);
		wait_for_drain();

		// Random traffic: mostly framed messages, some noise and broken headers
		while (counted_words < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				wait_for_drain();
			end else if (pick < 12) begin
				repeat ($urandom_range(1, 3))
					send_word(noise_byte(), 1'b0, 1'b0, NO_WORD);
			end else if (pick < 20) begin
				send_broken();
			end else begin
				send_frame(pick_length(), 1'b1);
			end
		end

		// Largest header value; the message is left open at the end of the run
		send_head(MAX_LEN);
		repeat (OPEN_TAIL)
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_WORD);

		byte_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (2 * LAT_SLACK) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== ascii_length_prefix_deframer.f =====
+incdir+rtl
rtl/alpd_pkg.sv
rtl/alpd_core.sv
rtl/alpd_out_reg.sv
rtl/ascii_length_prefix_deframer.sv
verif/testbench.sv
